// ===== sv/gcrg_pkg.sv =====
// Shared constants and the command type for the GF(256) coefficient row generator.
package gcrg_pkg;

    localparam int ADDR_W = 16;
    localparam int COEFS  = 6;
    localparam int MATS   = 3;

    localparam logic [ADDR_W-1:0] TABLE_DEPTH       = 16'd39936;
    localparam logic [ADDR_W-1:0] BASE_PHASE_STRIDE = 16'd6144;
    localparam logic [ADDR_W-1:0] MID10_BASE        = 16'd12288;
    localparam logic [ADDR_W-1:0] MID_PHASE_STRIDE  = 16'd4608;
    localparam logic [ADDR_W-1:0] MID17_BASE        = 16'd21504;
    localparam logic [ADDR_W-1:0] HIGH_BASE         = 16'd30720;
    localparam logic [ADDR_W-1:0] MATRIX_BYTES      = 16'd36;
    localparam logic [ADDR_W-1:0] ROW_BYTES         = 16'd6;

    localparam logic [8:0] POLY_RESET = 9'd333;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic                        is_query;
        logic [ADDR_W-1:0]           addr;      // write address, or base row address
        logic [7:0]                  wdata;
        logic [MATS-1:0][ADDR_W-1:0] mat_addr;  // matrix bases: bits 10-16, 17-23, 24-31
        logic [MATS-1:0]             mat_en;
    } cmd_t;

endpackage

// ===== sv/gf256_coefficient_row_generator_core.sv =====
// Top level of the GF(256) coefficient row generator.
//
// Input channel (s_valid/s_ready): each transfer is either a table write
// (s_action = 0: byte s_table_byte goes to s_table_address) or a row query
// (s_action = 1: the six coefficients for s_block_id are returned). Writes
// to addresses past the end of the table are dropped and give no result.
// Result channel (m_valid/m_ready): one transfer of m_coef_a..m_coef_f per
// query, in query order. Table entries must be written before a query uses them.
// Configuration: cfg_wr_en/cfg_wr_data load the 9-bit field polynomial;
// write it only while the block is idle.
//
// Timing: a front end decodes each item into a two-entry command queue, so
// up to two items are taken while the engine is busy. The engine has one
// table port and reads one byte per cycle: a write is a single table write,
// a query reads the six row bytes and then 36 bytes for each of the k (0..3)
// nonzero matrix fields of the id. A finished row sits in the output
// register while the engine goes on with the next command; a stalled
// receiver only holds the engine once it has the following row ready.
// Reset: clears the queue, the sequencer and the output valid; the polynomial
// returns to 0x14D. The table keeps whatever it held.
module gf256_coefficient_row_generator_core
    import gcrg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [15:0] s_table_address,
    input  logic [7:0]  s_table_byte,
    input  logic [31:0] s_block_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_coef_a,
    output logic [7:0]  m_coef_b,
    output logic [7:0]  m_coef_c,
    output logic [7:0]  m_coef_d,
    output logic [7:0]  m_coef_e,
    output logic [7:0]  m_coef_f
);

    logic [8:0]            poly_reg;
    logic                  q_push;
    logic                  q_in_ready;
    cmd_t                  q_in_cmd;
    logic                  q_valid;
    cmd_t                  q_cmd;
    logic                  q_pop;
    logic [COEFS-1:0][7:0] coef;
    logic [2:0]            pending_reg;
    logic [2:0]            pending_next;

    // Hold the field polynomial; load it on a config write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg <= POLY_RESET;
        end else if (cfg_wr_en) begin
            poly_reg <= cfg_wr_data;
        end
    end

    // Decode input transfers into commands
    gcrg_front u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_table_address (s_table_address),
        .s_table_byte    (s_table_byte),
        .s_block_id      (s_block_id),
        .q_push          (q_push),
        .q_cmd           (q_in_cmd),
        .q_ready         (q_in_ready)
    );

    // Buffer commands so front and engine stall independently
    gcrg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_push   (q_push),
        .in_cmd    (q_in_cmd),
        .in_ready  (q_in_ready),
        .out_valid (q_valid),
        .out_cmd   (q_cmd),
        .out_pop   (q_pop)
    );

    // Execute writes and queries against the table
    gcrg_engine u_engine (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .field_polynomial (poly_reg),
        .q_valid          (q_valid),
        .q_cmd            (q_cmd),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .coef             (coef)
    );

    assign m_coef_a = coef[0];
    assign m_coef_b = coef[1];
    assign m_coef_c = coef[2];
    assign m_coef_d = coef[3];
    assign m_coef_e = coef[4];
    assign m_coef_f = coef[5];

    // Track queries accepted but not yet delivered (queue + engine + output)
    always_comb begin
        pending_next = pending_reg;
        if (s_valid && s_ready && (s_action == ACT_QUERY)) begin
            pending_next = pending_next + 3'd1;
        end
        if (m_valid && m_ready) begin
            pending_next = pending_next - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // A result only appears for a query that was taken in
    a_no_orphan_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pending_reg != 3'd0))
        else $error("result transfer without an outstanding query");

    // At most two queued, one in the engine and one in the output register
    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 3'd4)
        else $error("more outstanding queries than the pipeline can hold");

    // No result is presented in the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

// ===== sv/gcrg_front.sv =====
// Front end: accepts input transfers and turns them into table write or row query commands.
module gcrg_front
    import gcrg_pkg::*;
(
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_action,
    input  logic [15:0]       s_table_address,
    input  logic [7:0]        s_table_byte,
    input  logic [31:0]       s_block_id,
    output logic              q_push,
    output cmd_t              q_cmd,
    input  logic              q_ready
);

    logic [7:0] high;
    logic [6:0] mid17;
    logic [6:0] mid10;
    logic [9:0] low;
    logic       p17;
    logic       p10;
    logic       p0;
    logic       addr_ok;

    assign high  = s_block_id[31:24];
    assign mid17 = s_block_id[23:17];
    assign mid10 = s_block_id[16:10];
    assign low   = s_block_id[9:0];

    // Thue-Morse phases chain down from the high part
    assign p17 = ^high;
    assign p10 = p17 ^ (^mid17);
    assign p0  = p10 ^ (^mid10);

    assign addr_ok = (s_table_address < TABLE_DEPTH);
    assign s_ready = q_ready;
    // drop writes beyond the table
    assign q_push  = s_valid && q_ready && ((s_action == ACT_QUERY) || addr_ok);

    always_comb begin
        q_cmd          = '0;
        q_cmd.is_query = (s_action == ACT_QUERY);
        q_cmd.wdata    = s_table_byte;
        if (s_action == ACT_QUERY) begin
            q_cmd.addr = (p0 ? BASE_PHASE_STRIDE : '0) + ADDR_W'(low) * ROW_BYTES;
        end else begin
            q_cmd.addr = s_table_address;
        end
        q_cmd.mat_addr[0] = MID10_BASE + (p10 ? MID_PHASE_STRIDE : '0)
                            + ADDR_W'(mid10) * MATRIX_BYTES;
        q_cmd.mat_addr[1] = MID17_BASE + (p17 ? MID_PHASE_STRIDE : '0)
                            + ADDR_W'(mid17) * MATRIX_BYTES;
        q_cmd.mat_addr[2] = HIGH_BASE + ADDR_W'(high) * MATRIX_BYTES;
        q_cmd.mat_en      = {(high != '0), (mid17 != '0), (mid10 != '0)};
    end

endmodule

// ===== sv/gcrg_queue.sv =====
// Two-entry command queue between the front end and the engine.
module gcrg_queue
    import gcrg_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_push,
    input  cmd_t in_cmd,
    output logic in_ready,
    output logic out_valid,
    output cmd_t out_cmd,
    input  logic out_pop
);

    cmd_t       ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = ent_reg[rd_ptr_reg];
    assign do_push   = in_push && in_ready;
    assign do_pop    = out_pop && out_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            ent_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

// ===== sv/gcrg_engine.sv =====
// Back end: coefficient table memory, row load and GF(256) matrix product sequencer.
module gcrg_engine
    import gcrg_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [8:0]             field_polynomial,
    input  logic                   q_valid,
    input  cmd_t                   q_cmd,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COEFS-1:0][7:0]  coef
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [1:0] PH_ROW  = 2'd0;
    localparam logic [1:0] PH_M10  = 2'd1;
    localparam logic [1:0] PH_M17  = 2'd2;
    localparam logic [1:0] PH_HIGH = 2'd3;

    localparam logic [2:0] LAST_IDX = 3'(COEFS - 1);

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                          input logic [8:0] poly);
        logic [8:0] x;
        logic [7:0] acc;
        x   = {1'b0, a};
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc ^= x[7:0];
            end
            x = x << 1;
            if (x[8]) begin
                x ^= poly;
            end
            x[8] = 1'b0;
        end
        return acc;
    endfunction

    logic [7:0] mem [TABLE_DEPTH];

    logic [1:0]                  state_reg, state_next;
    logic [1:0]                  phase_reg, phase_next;
    logic [2:0]                  r_reg, r_next;
    logic [2:0]                  c_reg, c_next;
    logic [ADDR_W-1:0]           row_addr_reg, row_addr_next;
    logic [MATS-1:0][ADDR_W-1:0] mat_addr_reg, mat_addr_next;
    logic [MATS-1:0]             mat_en_reg, mat_en_next;

    logic       rd_valid_reg, rd_valid_next;
    logic       rd_row_reg, rd_row_next;
    logic       rd_last_reg, rd_last_next;
    logic [2:0] rd_r_reg, rd_r_next;
    logic [2:0] rd_c_reg, rd_c_next;
    logic [7:0] rdata_reg;

    logic [7:0] vec_reg [COEFS];
    logic [7:0] vec_next [COEFS];
    logic [7:0] nxt_reg [COEFS];
    logic [7:0] nxt_next [COEFS];
    logic [7:0] acc_reg, acc_next;

    logic                  out_valid_reg, out_valid_next;
    logic [COEFS-1:0][7:0] out_reg, out_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [ADDR_W-1:0] issue_base;
    logic [5:0]        issue_off;
    logic              last_in_phase;
    logic              has_next;
    logic [1:0]        next_phase;
    logic [7:0]        prod;
    logic [7:0]        sum;

    always_comb begin
        case (phase_reg)
            PH_ROW:  issue_base = row_addr_reg;
            PH_M10:  issue_base = mat_addr_reg[0];
            PH_M17:  issue_base = mat_addr_reg[1];
            PH_HIGH: issue_base = mat_addr_reg[2];
            default: issue_base = row_addr_reg;
        endcase
    end

    assign issue_off     = 6'(r_reg) * 6'(COEFS) + 6'(c_reg);
    assign last_in_phase = (c_reg == LAST_IDX) && ((phase_reg == PH_ROW) || (r_reg == LAST_IDX));

    // pick the next enabled matrix after the current phase
    always_comb begin
        has_next   = 1'b1;
        next_phase = PH_HIGH;
        if ((phase_reg == PH_ROW) && mat_en_reg[0]) begin
            next_phase = PH_M10;
        end else if (((phase_reg == PH_ROW) || (phase_reg == PH_M10)) && mat_en_reg[1]) begin
            next_phase = PH_M17;
        end else if ((phase_reg != PH_HIGH) && mat_en_reg[2]) begin
            next_phase = PH_HIGH;
        end else begin
            has_next = 1'b0;
        end
    end

    assign prod = gf_mul(vec_reg[rd_c_reg], rdata_reg, field_polynomial);
    assign sum  = acc_reg ^ prod;

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        row_addr_next  = row_addr_reg;
        mat_addr_next  = mat_addr_reg;
        mat_en_next    = mat_en_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = issue_base + ADDR_W'(issue_off);

        rd_valid_next = (state_reg == ST_RUN);
        rd_row_next   = (phase_reg == PH_ROW);
        rd_last_next  = last_in_phase && (phase_reg != PH_ROW);
        rd_r_next     = r_reg;
        rd_c_next     = c_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                q_pop = 1'b1;
                if (q_valid) begin
                    if (q_cmd.is_query) begin
                        row_addr_next = q_cmd.addr;
                        mat_addr_next = q_cmd.mat_addr;
                        mat_en_next   = q_cmd.mat_en;
                        phase_next    = PH_ROW;
                        r_next        = '0;
                        c_next        = '0;
                        state_next    = ST_RUN;
                    end else begin
                        mem_we   = 1'b1;
                        mem_addr = q_cmd.addr;
                    end
                end
            end
            ST_RUN: begin
                if (last_in_phase) begin
                    r_next = '0;
                    c_next = '0;
                    if (has_next) begin
                        phase_next = next_phase;
                    end else begin
                        state_next = ST_DRAIN;
                    end
                end else if (c_reg == LAST_IDX) begin
                    c_next = '0;
                    r_next = r_reg + 3'd1;
                end else begin
                    c_next = c_reg + 3'd1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    for (int i = 0; i < COEFS; i++) begin
                        out_next[i] = vec_reg[i];
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // consume read data: load the base row or fold one matrix byte into the product
    always_comb begin
        for (int i = 0; i < COEFS; i++) begin
            vec_next[i] = vec_reg[i];
            nxt_next[i] = nxt_reg[i];
        end
        acc_next = acc_reg;
        if (rd_valid_reg) begin
            if (rd_row_reg) begin
                vec_next[rd_c_reg] = rdata_reg;
            end else begin
                if (rd_c_reg == LAST_IDX) begin
                    nxt_next[rd_r_reg] = sum;
                    acc_next           = '0;
                end else begin
                    acc_next = sum;
                end
                if (rd_last_reg) begin
                    for (int i = 0; i < COEFS - 1; i++) begin
                        vec_next[i] = nxt_reg[i];
                    end
                    vec_next[COEFS-1] = sum;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= q_cmd.wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        row_addr_reg <= row_addr_next;
        mat_addr_reg <= mat_addr_next;
        phase_reg    <= phase_next;
        r_reg        <= r_next;
        c_reg        <= c_next;
        rd_row_reg   <= rd_row_next;
        rd_last_reg  <= rd_last_next;
        rd_r_reg     <= rd_r_next;
        rd_c_reg     <= rd_c_next;
        out_reg      <= out_next;
        for (int i = 0; i < COEFS; i++) begin
            vec_reg[i] <= vec_next[i];
            nxt_reg[i] <= nxt_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mat_en_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mat_en_reg    <= mat_en_next;
            rd_valid_reg  <= rd_valid_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign coef    = out_reg;

endmodule
